// ===== design/dot_bracket_pair_matcher_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the dot-bracket pair matcher
// Shared concurrent-assertion shorthands, clocked on clock, off in reset.
// ---------------------------------------------------------------------------
`ifndef DOT_BRACKET_PAIR_MATCHER_DEFINES_SVH
`define DOT_BRACKET_PAIR_MATCHER_DEFINES_SVH

// same-cycle implication
`define DBPM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DBPM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dbpm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbpm_pkg
// Types and constants of the dot-bracket pair matcher.
// ---------------------------------------------------------------------------
package dbpm_pkg;

   localparam int MAX_LEN_DEFAULT = 1024;
   localparam int STACK_SIZE      = 1024;
   localparam int ADDR_W          = 10;   // stack index / reported position width
   localparam int DEPTH_W         = 11;   // stack depth, 0..STACK_SIZE
   localparam int SYM_W           = 8;
   localparam int STATUS_W        = 2;

   localparam logic [SYM_W-1:0] SYM_OPEN  = 8'd40;  // '('
   localparam logic [SYM_W-1:0] SYM_CLOSE = 8'd41;  // ')'

   typedef enum logic [STATUS_W-1:0] {
      ST_PAIR     = 2'd0,
      ST_NO_OPEN  = 2'd1,
      ST_END      = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             end_of_structure;
   } req_payload_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  open_pos;
      logic [ADDR_W-1:0]  close_pos;
      logic               is_terminal;
      logic               last_of_structure;
      logic [DEPTH_W-1:0] open_left;
   } rsp_payload_type;

   // stack command from the match logic
   typedef struct packed {
      logic              push;
      logic              pop;
      logic              clear;
      logic [ADDR_W-1:0] push_data;
   } stack_cmd_type;

   // stack view seen by the match logic
   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [ADDR_W-1:0]  top;
   } stack_view_type;

endpackage

// ===== design/dbpm_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbpm_req_if / dbpm_rsp_if
// Valid/ready channels for symbol requests and pair results.
// ---------------------------------------------------------------------------
interface dbpm_req_if import dbpm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             end_of_structure;

   modport source (output valid, symbol, end_of_structure, input ready);
   modport sink   (input valid, symbol, end_of_structure, output ready);
endinterface

interface dbpm_rsp_if import dbpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   open_pos;
   logic [ADDR_W-1:0]   close_pos;
   logic                is_terminal;
   logic                last_of_structure;
   logic [DEPTH_W-1:0]  open_left;

   modport source (output valid, status, open_pos, close_pos, is_terminal,
                   last_of_structure, open_left, input ready);
   modport sink   (input valid, status, open_pos, close_pos, is_terminal,
                   last_of_structure, open_left, output ready);
endinterface

// ===== design/dbpm_stack.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbpm_stack
// Open-position stack: top in a register, the rest in a 1R1W memory.
// ---------------------------------------------------------------------------
module dbpm_stack
   import dbpm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  stack_cmd_type  cmd,
   output stack_view_type view
);

   logic [ADDR_W-1:0]  mem [STACK_SIZE];
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [ADDR_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0]  rd_ff;
   logic               byp_ff;
   logic [ADDR_W-1:0]  byp_data_ff;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DEPTH_W-1:0] dm1, dm2;
   logic [ADDR_W-1:0]  below;

   // entry just under the top, read ahead into a register or forwarded from a write
   assign below = byp_ff ? byp_data_ff : rd_ff;

   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      if (cmd.push) begin
         depth_in = depth_ff + DEPTH_W'(1);
         top_in   = cmd.push_data;
      end else if (cmd.pop) begin
         depth_in = depth_ff - DEPTH_W'(1);
         top_in   = below;
      end
      if (cmd.clear) begin
         depth_in = '0;
      end
   end

   // old top spills to memory on a push
   assign dm1     = depth_ff - DEPTH_W'(1);
   assign dm2     = depth_in - DEPTH_W'(2);
   assign wr_en   = cmd.push && (depth_ff != '0);
   assign wr_addr = dm1[ADDR_W-1:0];
   assign rd_addr = dm2[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   // read-during-write forward
   always_ff @(posedge clock) begin
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= top_ff;
      top_ff      <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign view.depth = depth_ff;
   assign view.top   = top_ff;

endmodule

// ===== design/dbpm_match.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbpm_match
// Per-symbol decode: position count, pair match, terminal test, result.
// ---------------------------------------------------------------------------
module dbpm_match
   import dbpm_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type item,
   input  stack_view_type  view,
   output stack_cmd_type   cmd,
   output logic            produce,
   output rsp_payload_type result
);

   localparam int POS_W = $clog2(MAX_LEN + 1);

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    prev_closed_ff, prev_closed_in;
   logic [ADDR_W-1:0]       prev_open_ff, prev_open_in;
   logic [POS_W+ADDR_W-1:0] here_ext;
   logic [ADDR_W-1:0]       here;
   logic                    ovf, is_open, is_close, full;
   logic                    push, pop, no_open, full_ovf, emit, last;
   logic [DEPTH_W-1:0]      depth_after;
   logic [ADDR_W-1:0]       opos_inc;

   assign here_ext = {{ADDR_W{1'b0}}, pos_ff};
   assign here     = here_ext[ADDR_W-1:0];
   assign ovf      = pos_ff >= POS_W'(MAX_LEN);
   assign is_open  = item.symbol == SYM_OPEN;
   assign is_close = item.symbol == SYM_CLOSE;
   assign full     = view.depth == DEPTH_W'(STACK_SIZE);
   assign last     = item.end_of_structure;
   assign push     = !ovf && is_open && !full;
   assign full_ovf = !ovf && is_open && full;
   assign pop      = !ovf && is_close && (view.depth != '0);
   assign no_open  = !ovf && is_close && (view.depth == '0);
   assign emit     = ovf || full_ovf || is_close;
   assign opos_inc = view.top + ADDR_W'(1);

   always_comb begin
      depth_after = view.depth;
      if (push) begin
         depth_after = view.depth + DEPTH_W'(1);
      end else if (pop) begin
         depth_after = view.depth - DEPTH_W'(1);
      end
   end

   assign cmd.push      = fire && push;
   assign cmd.pop       = fire && pop;
   assign cmd.clear     = fire && last;
   assign cmd.push_data = here;
   assign produce       = emit || last;

   always_comb begin
      result.status            = ST_END;
      result.open_pos          = '0;
      result.close_pos         = here;
      result.is_terminal       = 1'b0;
      result.last_of_structure = last;
      result.open_left         = last ? depth_after : '0;
      if (ovf || full_ovf) begin
         result.status    = ST_OVERFLOW;
         result.close_pos = '0;
      end else if (pop) begin
         result.status      = ST_PAIR;
         result.open_pos    = view.top;
         result.is_terminal = !(prev_closed_ff && (prev_open_ff == opos_inc));
      end else if (no_open) begin
         result.status = ST_NO_OPEN;
      end
   end

   always_comb begin
      pos_in         = pos_ff;
      prev_closed_in = prev_closed_ff;
      prev_open_in   = prev_open_ff;
      if (fire) begin
         if (!ovf) begin
            pos_in = pos_ff + POS_W'(1);
         end
         prev_closed_in = pop;
         if (pop) begin
            prev_open_in = view.top;
         end
         if (last) begin
            pos_in         = '0;
            prev_closed_in = 1'b0;
            prev_open_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         prev_closed_ff <= 1'b0;
         prev_open_ff   <= '0;
      end else begin
         pos_ff         <= pos_in;
         prev_closed_ff <= prev_closed_in;
         prev_open_ff   <= prev_open_in;
      end
   end

endmodule

// ===== design/dot_bracket_pair_matcher.sv =====
`timescale 1ns / 1ps
// Path: a request is held in the input register, its result in the result register.
// Throughput: one request per cycle unless a result stalls; set by the single
//   pop per cycle on the open stack, whose next-below entry is read ahead.
// Reset: synchronous, active high; clears position, stack depth, pair
//   memory and both valid flags. The stack memory is not cleared.
// ---------------------------------------------------------------------------
// dot_bracket_pair_matcher
// Streams a dot-bracket structure and reports base pairs as they close.
// ---------------------------------------------------------------------------
module dot_bracket_pair_matcher
   import dbpm_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   dbpm_req_if.sink   req_ch,
   dbpm_rsp_if.source rsp_ch
);

   // Input register: holds one request. It refills whenever its request
   // moves on, so a stalled result still leaves room for one more request.
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_ff;

   // Result register feeding the response channel.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;

   // Request in the input register is processed when the result slot
   // is free or being drained this cycle.
   logic            fire;
   logic            req_take;
   logic            produce;
   rsp_payload_type result;
   stack_cmd_type   cmd;
   stack_view_type  view;

   assign fire         = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || fire;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.symbol           <= req_ch.symbol;
         in_ff.end_of_structure <= req_ch.end_of_structure;
      end
   end

   // Match logic: position, pair test, result formatting.
   dbpm_match #(
      .MAX_LEN (MAX_LEN)
   ) u_match (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_ff),
      .view    (view),
      .cmd     (cmd),
      .produce (produce),
      .result  (result)
   );

   // Open-position stack.
   dbpm_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .view  (view)
   );

   // Result register: loads only for requests that report something
   // (a close, an overflow, or the end of the structure).
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && produce) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = rsp_ff.status;
   assign rsp_ch.open_pos          = rsp_ff.open_pos;
   assign rsp_ch.close_pos         = rsp_ff.close_pos;
   assign rsp_ch.is_terminal       = rsp_ff.is_terminal;
   assign rsp_ch.last_of_structure = rsp_ff.last_of_structure;
   assign rsp_ch.open_left         = rsp_ff.open_left;

endmodule

// ===== design/dbpm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbpm_checker
// Port-level checks on the result channel of the pair matcher.
// ---------------------------------------------------------------------------
`include "dot_bracket_pair_matcher_defines.svh"

module dbpm_checker
   import dbpm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ADDR_W-1:0]   rsp_open_pos,
   input logic [ADDR_W-1:0]   rsp_close_pos,
   input logic                rsp_is_terminal,
   input logic                rsp_last_of_structure,
   input logic [DEPTH_W-1:0]  rsp_open_left
);

   `DBPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_open_pos) && $stable(rsp_close_pos) && $stable(rsp_open_left), "stalled response changed")
   `DBPM_ASSERT_NOW(a_open_left_last, rsp_valid && !rsp_last_of_structure, rsp_open_left == '0, "open count on non-final response")
   `DBPM_ASSERT_NOW(a_ovf_close, rsp_valid && (rsp_status == ST_OVERFLOW), rsp_close_pos == '0, "overflow response carries a position")
   `DBPM_ASSERT_NOW(a_nopair_fields, rsp_valid && (rsp_status != ST_PAIR), (rsp_open_pos == '0) && !rsp_is_terminal, "pair fields set without a pair")

endmodule

bind dot_bracket_pair_matcher dbpm_checker u_dbpm_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_status            (rsp_ch.status),
   .rsp_open_pos          (rsp_ch.open_pos),
   .rsp_close_pos         (rsp_ch.close_pos),
   .rsp_is_terminal       (rsp_ch.is_terminal),
   .rsp_last_of_structure (rsp_ch.last_of_structure),
   .rsp_open_left         (rsp_ch.open_left)
);
